[rtl/core/crc_checked_register_command_frame_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-checked command frame core
// Shared concurrent assertion forms. They are sampled on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_REGISTER_COMMAND_FRAME_CORE_ASSERT_SVH
`define CRC_CHECKED_REGISTER_COMMAND_FRAME_CORE_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define CRCCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be seen outside reset.
`define CRCCF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/core/crccf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crccf_pkg
// Types, constants and the CRC-16/X.25 byte update shared by the frame core.
// ----------------------------------------------------------------------------
package crccf_pkg;

  // CRC-16/X.25: reflected polynomial, all-ones start, final complement.
  localparam logic [15:0] CrcPoly = 16'h8408;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // Reply codes.
  localparam logic [7:0] AckByte   = 8'h05;
  localparam logic [7:0] NackByte  = 8'h15;
  localparam logic [7:0] EmptyByte = 8'hFF;

  // Operation codes.
  localparam logic [7:0] OpRead  = 8'd1;
  localparam logic [7:0] OpWrite = 8'd2;

  // Selector codes.
  localparam logic [7:0] SelVersion = 8'd0;
  localparam logic [7:0] SelTime    = 8'd1;
  localparam logic [7:0] SelDate    = 8'd2;
  localparam logic [7:0] SelAlarm   = 8'd3;

  // Register reset values.
  localparam logic [7:0] VersionReset  = 8'd1;
  localparam logic [7:0] RevisionReset = 8'd2;

  // Frame layout: byte positions counted from zero.
  localparam int unsigned FrameLen = 7;
  localparam int unsigned BodyLen  = 5;
  localparam logic [2:0]  PosOp    = 3'd0;
  localparam logic [2:0]  PosSel   = 3'd1;
  localparam logic [2:0]  PosPay0  = 3'd2;
  localparam logic [2:0]  PosPay1  = 3'd3;
  localparam logic [2:0]  PosPay2  = 3'd4;
  localparam logic [2:0]  PosCrcLo = 3'd5;
  localparam logic [2:0]  PosCrcHi = 3'd6;

  // Default depth of the command queue between front and back.
  localparam int unsigned CmdQueueDepth = 2;

  // One checked command, as handed from the front to the back.
  typedef struct packed {
    logic            crc_ok;
    logic [7:0]      op;
    logic [7:0]      sel;
    logic [2:0][7:0] pay;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic {
    BIdle,
    BSend
  } back_state_e;

  // Advance the CRC by one byte, least significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] a;
    a = acc;
    for (int b = 0; b < 8; b++) begin
      if (a[0] ^ data[b]) begin
        a = (a >> 1) ^ CrcPoly;
      end else begin
        a = a >> 1;
      end
    end
    return a;
  endfunction

endpackage

[rtl/core/crccf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crccf_if
// Valid/ready byte channels: the receive side and the transmit side.
// ----------------------------------------------------------------------------

// Received byte channel.
interface crccf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Transmit byte channel; last_byte marks the end of a reply run.
interface crccf_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

[rtl/core/crccf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crccf_front
// Collects seven-byte frames, runs the CRC as bytes arrive and pushes one
// checked command per frame into the command queue.
// ----------------------------------------------------------------------------
module crccf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  crccf_rx_if.sink          rx_i,
  output crccf_pkg::cmd_t   cmd_o,
  output logic              push_o,
  input  logic              full_i
);
  import crccf_pkg::*;

  logic [2:0]      count_q, count_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      op_q, sel_q, crc_lo_q;
  logic [2:0][7:0] pay_q;
  logic            take;
  logic            last_pos;

  // The seventh byte waits only when the queue has no room for its command.
  assign last_pos     = (count_q == PosCrcHi);
  assign rx_i.ready   = !(last_pos && full_i);
  assign take         = rx_i.valid && rx_i.ready;
  assign push_o       = take && last_pos;

  // The finished command: CRC bytes arrive low first and are compared whole.
  always_comb begin
    cmd_o.crc_ok = ({rx_i.rx_byte, crc_lo_q} == ~crc_q);
    cmd_o.op     = op_q;
    cmd_o.sel    = sel_q;
    cmd_o.pay    = pay_q;
  end

  // Byte position and running CRC.
  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    if (take) begin
      if (last_pos) begin
        count_d = '0;
      end else begin
        count_d = count_q + 3'd1;
      end
      if (count_q == PosOp) begin
        crc_d = crc_byte(CrcInit, rx_i.rx_byte);
      end else if (count_q < PosCrcLo) begin
        crc_d = crc_byte(crc_q, rx_i.rx_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Frame bytes and CRC state need no reset.
  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (take) begin
      unique case (count_q)
        PosOp:    op_q     <= rx_i.rx_byte;
        PosSel:   sel_q    <= rx_i.rx_byte;
        PosPay0:  pay_q[0] <= rx_i.rx_byte;
        PosPay1:  pay_q[1] <= rx_i.rx_byte;
        PosPay2:  pay_q[2] <= rx_i.rx_byte;
        PosCrcLo: crc_lo_q <= rx_i.rx_byte;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/crccf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crccf_queue
// Short first-in first-out queue of checked commands between the front and
// the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module crccf_queue #(
  parameter int unsigned Depth = crccf_pkg::CmdQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crccf_pkg::cmd_t cmd_i,
  input  logic            push_i,
  output logic            full_o,
  output crccf_pkg::cmd_t cmd_o,
  output logic            valid_o,
  input  logic            pop_i
);
  import crccf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;
  logic            do_push, do_pop;

  assign full_o  = (fill_q == CntW'(Depth));
  assign valid_o = (fill_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[rtl/core/crccf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crccf_back
// Carries out checked commands: answers NACK or ACK, updates the register
// file, and sends the five response bytes followed by their CRC.
// ----------------------------------------------------------------------------
module crccf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crccf_pkg::cmd_t cmd_i,
  input  logic            cmd_valid_i,
  output logic            pop_o,
  crccf_tx_if.source      tx_o
);
  import crccf_pkg::*;

  back_state_e     state_q, state_d;
  logic [2:0]      idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic            tx_valid_q, tx_valid_d;
  logic [7:0]      tx_byte_q, tx_byte_d;
  logic            last_q, last_d;
  logic            slot_free, load, run;

  logic [7:0]      ver_q, ver_d, rev_q, rev_d;
  logic [2:0][7:0] time_q, time_d, date_q, date_d, alarm_q, alarm_d;
  logic [4:0][7:0] resp_q, resp_d;

  assign tx_o.valid     = tx_valid_q;
  assign tx_o.tx_byte   = tx_byte_q;
  assign tx_o.last_byte = last_q;

  // The output register can take a new request when empty or being drained.
  assign slot_free = !tx_valid_q || tx_o.ready;
  assign pop_o     = (state_q == BIdle) && cmd_valid_i && slot_free;

  // Sequencer: one reply byte per free output slot.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    crc_d     = crc_q;
    load      = 1'b0;
    run       = 1'b0;
    tx_byte_d = tx_byte_q;
    last_d    = last_q;
    unique case (state_q)
      BIdle: begin
        if (pop_o) begin
          load = 1'b1;
          if (cmd_i.crc_ok) begin
            tx_byte_d = AckByte;
            last_d    = 1'b0;
            run       = 1'b1;
            idx_d     = '0;
            crc_d     = CrcInit;
            state_d   = BSend;
          end else begin
            tx_byte_d = NackByte;
            last_d    = 1'b1;
          end
        end
      end
      BSend: begin
        if (slot_free) begin
          load  = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q < PosCrcLo) begin
            tx_byte_d = resp_q[idx_q];
            last_d    = 1'b0;
            crc_d     = crc_byte(crc_q, resp_q[idx_q]);
          end else if (idx_q == PosCrcLo) begin
            tx_byte_d = ~crc_q[7:0];
            last_d    = 1'b0;
          end else begin
            tx_byte_d = ~crc_q[15:8];
            last_d    = 1'b1;
            state_d   = BIdle;
          end
        end
      end
      default: begin
        state_d = BIdle;
      end
    endcase
    if (load) begin
      tx_valid_d = 1'b1;
    end else if (tx_o.ready) begin
      tx_valid_d = 1'b0;
    end else begin
      tx_valid_d = tx_valid_q;
    end
  end

  // Command execution: response store and register updates.
  always_comb begin
    ver_d   = ver_q;
    rev_d   = rev_q;
    time_d  = time_q;
    date_d  = date_q;
    alarm_d = alarm_q;
    resp_d  = resp_q;
    if (run) begin
      if (cmd_i.op == OpRead) begin
        resp_d[0] = cmd_i.op;
        resp_d[1] = cmd_i.sel;
        unique case (cmd_i.sel)
          SelVersion: begin
            resp_d[2] = ver_q;
            resp_d[3] = rev_q;
            resp_d[4] = EmptyByte;
          end
          SelTime:  resp_d[4:2] = time_q;
          SelDate:  resp_d[4:2] = date_q;
          SelAlarm: resp_d[4:2] = alarm_q;
          default: begin
          end
        endcase
      end else if (cmd_i.op == OpWrite) begin
        resp_d = {cmd_i.pay, cmd_i.sel, cmd_i.op};
        unique case (cmd_i.sel)
          SelVersion: begin
            ver_d = cmd_i.pay[0];
            rev_d = cmd_i.pay[1];
          end
          SelTime:  time_d  = cmd_i.pay;
          SelDate:  date_d  = cmd_i.pay;
          SelAlarm: alarm_d = cmd_i.pay;
          default: begin
          end
        endcase
      end
    end
  end

  // Control state and the register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BIdle;
      tx_valid_q <= 1'b0;
      ver_q      <= VersionReset;
      rev_q      <= RevisionReset;
      time_q     <= '0;
      date_q     <= '0;
      alarm_q    <= '0;
      resp_q     <= '0;
    end else begin
      state_q    <= state_d;
      tx_valid_q <= tx_valid_d;
      ver_q      <= ver_d;
      rev_q      <= rev_d;
      time_q     <= time_d;
      date_q     <= date_d;
      alarm_q    <= alarm_d;
      resp_q     <= resp_d;
    end
  end

  // Reply payload and byte sequencing state.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    crc_q     <= crc_d;
    tx_byte_q <= tx_byte_d;
    last_q    <= last_d;
  end

endmodule

[rtl/core/crc_checked_register_command_frame_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_register_command_frame_core
// Receives seven-byte command frames protected by CRC-16/X.25 and answers
// each with NACK, or with ACK and a seven-byte response carrying its own CRC.
//
//   Channel  Direction  Payload               Request
//   rx_i     in         rx_byte[7:0]          one received byte
//   tx_o     out        tx_byte[7:0], last    one reply byte
//
// The front takes one byte per cycle; only the seventh byte of a frame waits,
// and only while the command queue is full.
// A bad frame gives one NACK byte; a good frame gives eight reply bytes, one
// per cycle while tx_o is ready, the first in the cycle after the back takes it.
// The back sequencer handles one command at a time; the queue holds the rest.
// Reset is asynchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
module crc_checked_register_command_frame_core #(
  parameter int unsigned QueueDepth = crccf_pkg::CmdQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crccf_rx_if.sink    rx_i,
  crccf_tx_if.source  tx_o
);
  import crccf_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, full, cmd_valid, pop;

  // Frame assembly and CRC check.
  crccf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .cmd_o  (push_cmd),
    .push_o (push),
    .full_i (full)
  );

  // Command queue.
  crccf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (push_cmd),
    .push_i  (push),
    .full_o  (full),
    .cmd_o   (pop_cmd),
    .valid_o (cmd_valid),
    .pop_i   (pop)
  );

  // Execution and reply.
  crccf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .cmd_valid_i (cmd_valid),
    .pop_o       (pop),
    .tx_o        (tx_o)
  );

endmodule

[rtl/core/crccf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crccf_checker
// Port-level checks of the reply stream, bound to the frame core.
// ----------------------------------------------------------------------------
`include "crc_checked_register_command_frame_core_assert.svh"

module crccf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tx_valid_i,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       last_byte_i
);
  import crccf_pkg::*;

  logic       in_run_q;
  logic [2:0] run_cnt_q;
  logic       tx_take;

  assign tx_take = tx_valid_i && tx_ready_i;

  // Track position inside the current reply run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q  <= 1'b0;
      run_cnt_q <= '0;
    end else if (tx_take) begin
      if (last_byte_i) begin
        in_run_q  <= 1'b0;
        run_cnt_q <= '0;
      end else begin
        in_run_q  <= 1'b1;
        run_cnt_q <= run_cnt_q + 3'd1;
      end
    end
  end

  // A run opens with NACK alone or with ACK followed by more bytes.
  `CRCCF_ASSERT(a_run_start, tx_valid_i && !in_run_q |-> (tx_byte_i == NackByte && last_byte_i) || (tx_byte_i == AckByte && !last_byte_i), "reply run does not open with ACK or NACK")
  // An acknowledged run is exactly eight bytes long.
  `CRCCF_ASSERT(a_run_length, tx_valid_i && in_run_q |-> (last_byte_i == (run_cnt_q == 3'd7)), "reply run length is not eight bytes")
  // A stalled reply byte stays offered.
  `CRCCF_ASSERT(a_tx_hold, tx_valid_i && !tx_ready_i |=> tx_valid_i, "reply byte withdrawn while stalled")
  // A stalled reply byte keeps its value.
  `CRCCF_ASSERT(a_tx_stable, tx_valid_i && !tx_ready_i |=> $stable(tx_byte_i) && $stable(last_byte_i), "reply byte changed while stalled")

endmodule

bind crc_checked_register_command_frame_core crccf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .tx_valid_i  (tx_o.valid),
  .tx_ready_i  (tx_o.ready),
  .tx_byte_i   (tx_o.tx_byte),
  .last_byte_i (tx_o.last_byte)
);
